// ----- sv/yfsc_pkg.sv -----
// Package for the YUV frame size and format check core.
// Holds the subsampling codes, component order codes, register indexes, lookup
// functions and result flag struct; depends on nothing.
package yfsc_pkg;

  localparam int DIM_BITS_DEF = 16;   // default width of the frame dimensions in use
  localparam int FIELD_W      = 16;   // width of each dimension field on the bus
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 56;   // 49 bits of result, padded to whole bytes
  localparam int BYTES_W      = 35;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 5;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  localparam logic [4:0] MIN_SAMPLE_BITS = 5'd7;
  localparam logic [4:0] DEPTH_LO        = 5'd8;
  localparam logic [4:0] DEPTH_HI        = 5'd16;

  typedef enum logic [2:0] {
    SS_444     = 3'd0,
    SS_422     = 3'd1,
    SS_420     = 3'd2,
    SS_440     = 3'd3,
    SS_410     = 3'd4,
    SS_411     = 3'd5,
    SS_400     = 3'd6,
    SS_UNKNOWN = 3'd7
  } ss_e;

  typedef enum logic [2:0] {
    CFG_SUBSAMPLING = 3'd0,
    CFG_SAMPLE_BITS = 3'd1,
    CFG_PLANAR      = 3'd2,
    CFG_ORDER       = 3'd3,
    CFG_BYTE_PACK   = 3'd4,
    CFG_UV_ILV      = 3'd5,
    CFG_OFFSET_X    = 3'd6,
    CFG_OFFSET_Y    = 3'd7
  } cfg_idx_e;

  // Component order codes; planar and packed layouts share the register.
  localparam logic [3:0] ORD_YUV     = 4'd0;
  localparam logic [3:0] ORD_P_YUVA  = 4'd2;
  localparam logic [3:0] ORD_P_YVUA  = 4'd3;
  localparam logic [3:0] ORD_AYUV    = 4'd2;
  localparam logic [3:0] ORD_VUYA    = 4'd4;
  localparam logic [3:0] ORD_UYVY    = 4'd5;
  localparam logic [3:0] ORD_YVYU    = 4'd8;
  localparam logic [3:0] ORD_UNKNOWN = 4'd9;

  typedef struct packed {
    logic       size_unknown;
    logic       format_valid;
    logic       rgb_convertible;
    logic [4:0] refusal_mask;
    logic [2:0] chroma_step_x;
    logic [2:0] chroma_step_y;
  } flags_t;

  // log2 of the horizontal chroma step
  function automatic logic [1:0] step_lx(ss_e ss);
    logic [1:0] r;
    case (ss)
      SS_410, SS_411: r = 2'd2;
      SS_422, SS_420: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  // log2 of the vertical chroma step
  function automatic logic [1:0] step_ly(ss_e ss);
    logic [1:0] r;
    case (ss)
      SS_410:         r = 2'd2;
      SS_420, SS_440: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  // Largest legal chroma offset for each subsampling
  function automatic logic [2:0] max_offset(logic hor, ss_e ss);
    logic [2:0] r;
    case (ss)
      SS_444:  r = 3'd1;
      SS_422:  r = hor ? 3'd3 : 3'd1;
      SS_420:  r = 3'd3;
      SS_440:  r = hor ? 3'd1 : 3'd3;
      SS_410:  r = 3'd7;
      SS_411:  r = hor ? 3'd7 : 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/yuv_frame_size_and_format_check_core.sv -----
// YUV frame size and format check core: top level, single module.
// Uses yfsc_pkg for codes, lookup functions and the result flag struct.
//
// Takes one frame size (width, height) per item and returns one result item
// with the frame buffer size in bytes for the YUV format held in the eight
// configuration registers, plus format validity, RGB convertibility with a
// refusal mask, and the chroma subsampling steps. The core is a four-stage
// pipeline: entry (format checks, chroma dimensions, per-format byte
// multipliers), area products (width x height, chroma width x chroma height),
// scaling by the byte multipliers, and sum with saturation at 2^35-1 into
// the output register. A new item is taken every cycle while the pipeline
// is not stalled by back-pressure; each result passes the entry, area,
// scaling and output registers in order before it reaches the master side.
// Each stage holds its item while the stage after it is full and stalled, so
// back-pressure propagates without losing or repeating items. Write the
// configuration only while no item is in flight.
module yuv_frame_size_and_format_check_core #(
  parameter int DIM_BITS = yfsc_pkg::DIM_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [yfsc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [yfsc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input items
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [yfsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,   // frame_width, frame_height
  // result items
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // frame_bytes, size_unknown, format_valid, rgb_convertible, refusal_mask,
  // chroma_step_x, chroma_step_y, zero pad
  output logic [yfsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  // Dimension bits in use: never wider than the bus field.
  localparam int DW = (DIM_BITS < yfsc_pkg::FIELD_W) ? DIM_BITS : yfsc_pkg::FIELD_W;
  localparam int PW = 2 * DW;          // area product
  localparam int TW = PW + 5;          // area times byte multiplier (up to 16)
  localparam int SW = TW + 1;          // luma plus chroma term
  localparam int EW = (SW > yfsc_pkg::BYTES_W) ? SW : yfsc_pkg::BYTES_W + 1;
  localparam int PAD_W = yfsc_pkg::OUT_TDATA_W - yfsc_pkg::BYTES_W - 14;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  yfsc_pkg::ss_e     ss_q;
  logic [4:0]        bits_q;
  logic              planar_q;
  logic [3:0]        order_q;
  logic              bpack_q;
  logic              uvilv_q;
  logic [3:0]        offx_q;
  logic [3:0]        offy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q     <= yfsc_pkg::SS_420;
      bits_q   <= 5'd8;
      planar_q <= 1'b1;
      order_q  <= yfsc_pkg::ORD_YUV;
      bpack_q  <= 1'b0;
      uvilv_q  <= 1'b0;
      offx_q   <= 4'd0;
      offy_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (yfsc_pkg::cfg_idx_e'(cfg_idx_i))
        yfsc_pkg::CFG_SUBSAMPLING: ss_q     <= yfsc_pkg::ss_e'(cfg_wdata_i[2:0]);
        yfsc_pkg::CFG_SAMPLE_BITS: bits_q   <= cfg_wdata_i;
        yfsc_pkg::CFG_PLANAR:      planar_q <= cfg_wdata_i[0];
        yfsc_pkg::CFG_ORDER:       order_q  <= cfg_wdata_i[3:0];
        yfsc_pkg::CFG_BYTE_PACK:   bpack_q  <= cfg_wdata_i[0];
        yfsc_pkg::CFG_UV_ILV:      uvilv_q  <= cfg_wdata_i[0];
        yfsc_pkg::CFG_OFFSET_X:    offx_q   <= cfg_wdata_i[3:0];
        yfsc_pkg::CFG_OFFSET_Y:    offy_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage takes a new item when empty or when the next
  // stage takes its current one.
  // ---------------------------------------------------------------------------
  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !vld4_q || m_axis_tready_i;
  assign rdy3 = !vld3_q || rdy4;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;

  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= s_axis_tvalid_i;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry: format checks, chroma dimensions and byte multipliers
  // ---------------------------------------------------------------------------
  logic [DW-1:0]    w_in, h_in;
  logic [1:0]       lx, ly;
  logic             fmt_ok, alpha;
  logic [5:0]       bits_rnd;
  logic [2:0]       bps;
  logic [7:0]       k422_rnd;
  logic [6:0]       bpp444;
  logic [7:0]       k444_rnd;
  yfsc_pkg::flags_t flags1_d;
  logic [DW-1:0]    w1_d, h1_d, cw1_d, ch1_d;
  logic [4:0]       m1_1_d, m2_1_d;

  assign w_in = s_axis_tdata_i[DW-1:0];
  assign h_in = s_axis_tdata_i[yfsc_pkg::FIELD_W +: DW];

  always_comb begin
    lx = yfsc_pkg::step_lx(ss_q);
    ly = yfsc_pkg::step_ly(ss_q);

    // Validity of the format itself
    fmt_ok = 1'b1;
    if (!planar_q) begin
      if (order_q <= yfsc_pkg::ORD_VUYA && ss_q != yfsc_pkg::SS_444) fmt_ok = 1'b0;
      if (order_q >= yfsc_pkg::ORD_UYVY && order_q <= yfsc_pkg::ORD_YVYU &&
          ss_q != yfsc_pkg::SS_422) fmt_ok = 1'b0;
      if (order_q >= yfsc_pkg::ORD_UNKNOWN) fmt_ok = 1'b0;
      if (ss_q >= yfsc_pkg::SS_420 && ss_q <= yfsc_pkg::SS_400) fmt_ok = 1'b0;
      if (uvilv_q) fmt_ok = 1'b0;
    end else if (order_q > yfsc_pkg::ORD_P_YVUA) begin
      fmt_ok = 1'b0;
    end
    // Offsets must be non-negative and within the subsampling limit, except for 4:0:0
    if (ss_q != yfsc_pkg::SS_400) begin
      if (offx_q[3] || offx_q[2:0] > yfsc_pkg::max_offset(1'b1, ss_q)) fmt_ok = 1'b0;
      if (offy_q[3] || offy_q[2:0] > yfsc_pkg::max_offset(1'b0, ss_q)) fmt_ok = 1'b0;
    end
    if (bits_q < yfsc_pkg::MIN_SAMPLE_BITS) fmt_ok = 1'b0;

    flags1_d.size_unknown  = (ss_q == yfsc_pkg::SS_UNKNOWN);
    flags1_d.format_valid  = fmt_ok;
    flags1_d.chroma_step_x = 3'(3'd1 << lx);
    flags1_d.chroma_step_y = 3'(3'd1 << ly);
    flags1_d.refusal_mask  = '0;
    if (fmt_ok) begin
      flags1_d.refusal_mask[0] = (bits_q < yfsc_pkg::DEPTH_LO) || (bits_q > yfsc_pkg::DEPTH_HI);
      // steps are powers of two: the remainder is the low bits
      flags1_d.refusal_mask[1] = |(w_in & DW'((1 << lx) - 1));
      flags1_d.refusal_mask[2] = |(h_in & DW'((1 << ly) - 1));
      flags1_d.refusal_mask[3] = (ss_q == yfsc_pkg::SS_UNKNOWN);
      flags1_d.refusal_mask[4] = !planar_q && ss_q != yfsc_pkg::SS_444 &&
                                 ss_q != yfsc_pkg::SS_422;
    end
    flags1_d.rgb_convertible = fmt_ok && (flags1_d.refusal_mask == 5'd0);

    // Alpha plane or alpha sample counts as one more luma-sized term
    alpha = (planar_q && (order_q == yfsc_pkg::ORD_P_YUVA || order_q == yfsc_pkg::ORD_P_YVUA)) ||
            (!planar_q && ss_q == yfsc_pkg::SS_444 &&
             order_q >= yfsc_pkg::ORD_AYUV && order_q <= yfsc_pkg::ORD_VUYA);

    bits_rnd = {1'b0, bits_q} + 6'd7;
    bps      = bits_rnd[5:3];
    k422_rnd = {1'b0, bits_q, 2'b00} + 8'd7;
    bpp444   = {2'b00, bits_q} + {1'b0, bits_q, 1'b0} + (alpha ? {2'b00, bits_q} : 7'd0);
    k444_rnd = {1'b0, bpp444} + 8'd7;

    // bytes = m1 * (w * h) + m2 * (cw * ch)
    m1_1_d = 5'd0;
    m2_1_d = 5'd0;
    if (ss_q != yfsc_pkg::SS_UNKNOWN) begin
      if (planar_q || !bpack_q) begin
        m1_1_d = alpha ? {1'b0, bps, 1'b0} : {2'b00, bps};
        m2_1_d = (ss_q == yfsc_pkg::SS_400) ? 5'd0 : {1'b0, bps, 1'b0};
      end else if (ss_q == yfsc_pkg::SS_422) begin
        m2_1_d = k422_rnd[7:3];
      end else if (ss_q == yfsc_pkg::SS_444) begin
        m1_1_d = k444_rnd[7:3];
      end
    end

    w1_d  = w_in;
    h1_d  = h_in;
    cw1_d = w_in >> lx;
    ch1_d = h_in >> ly;
  end

  yfsc_pkg::flags_t flags1_q, flags2_q, flags3_q, flags4_q;
  logic [DW-1:0]    w1_q, h1_q, cw1_q, ch1_q;
  logic [4:0]       m1_1_q, m2_1_q, m1_2_q, m2_2_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid_i) begin
      flags1_q <= flags1_d;
      w1_q     <= w1_d;
      h1_q     <= h1_d;
      cw1_q    <= cw1_d;
      ch1_q    <= ch1_d;
      m1_1_q   <= m1_1_d;
      m2_1_q   <= m2_1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: luma and chroma areas
  // ---------------------------------------------------------------------------
  logic [PW-1:0] area_l2_d, area_c2_d, area_l2_q, area_c2_q;

  assign area_l2_d = PW'(w1_q) * PW'(h1_q);
  assign area_c2_d = PW'(cw1_q) * PW'(ch1_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && vld1_q) begin
      area_l2_q <= area_l2_d;
      area_c2_q <= area_c2_d;
      m1_2_q    <= m1_1_q;
      m2_2_q    <= m2_1_q;
      flags2_q  <= flags1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale areas by bytes per sample group
  // ---------------------------------------------------------------------------
  logic [TW-1:0] term_l3_d, term_c3_d, term_l3_q, term_c3_q;

  assign term_l3_d = TW'(area_l2_q) * TW'(m1_2_q);
  assign term_c3_d = TW'(area_c2_q) * TW'(m2_2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && vld2_q) begin
      term_l3_q <= term_l3_d;
      term_c3_q <= term_c3_d;
      flags3_q  <= flags2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sum, saturate, hold in the output register
  // ---------------------------------------------------------------------------
  logic [EW-1:0]                   sum_ext;
  logic [yfsc_pkg::BYTES_W-1:0]    bytes4_d, bytes4_q;

  always_comb begin
    sum_ext = EW'(SW'(term_l3_q) + SW'(term_c3_q));
    if (sum_ext > EW'(yfsc_pkg::BYTES_MAX)) begin
      bytes4_d = yfsc_pkg::BYTES_MAX;
    end else begin
      bytes4_d = sum_ext[yfsc_pkg::BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && vld3_q) begin
      bytes4_q <= bytes4_d;
      flags4_q <= flags3_q;
    end
  end

  assign m_axis_tvalid_o = vld4_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}},
                            flags4_q.chroma_step_y,
                            flags4_q.chroma_step_x,
                            flags4_q.refusal_mask,
                            flags4_q.rgb_convertible,
                            flags4_q.format_valid,
                            flags4_q.size_unknown,
                            bytes4_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_fills_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld1_q)
    else $error("accepted item did not reach the entry stage");

  a_stall_holds_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q && !rdy3 |=> vld2_q && $stable(area_l2_q) && $stable(area_c2_q))
    else $error("stalled item lost in stage 2");

  a_mask_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q && !flags4_q.format_valid |-> flags4_q.refusal_mask == 5'd0 &&
                                         !flags4_q.rgb_convertible)
    else $error("refusal reported for an invalid format");

  a_unknown_no_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q && flags4_q.size_unknown |-> bytes4_q == '0 &&
                                        flags4_q.chroma_step_x == 3'd1 &&
                                        flags4_q.chroma_step_y == 3'd1)
    else $error("size reported for unknown subsampling");

endmodule
